FILE: rtl/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue unit.
// Used inside modules that have clk and an active-high synchronous rst.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Shared codes for the sorted priority queue unit.
// No dependencies.
package spq_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_REMOVED  = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

endpackage

FILE: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: DEPTH entries in one memory, head at address 0.
// Depends on spq_pkg and sorted_priority_queue_unit_assert.svh.
// One transaction at a time, taken only while not busy; an empty remove or a full insert
// finishes without touching the memory. Walks move one entry per cycle over a memory with
// one write and one registered read port, using one comparator.
// The receiver cannot stall. Reset (rst, sync, high) empties the queue, memory kept.
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 16,
  parameter int ID_BITS       = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [PRIORITY_BITS-1:0]       priority_req,
  input  logic [ID_BITS-1:0]             client_id,
  // result side, one-cycle strobe
  output logic                           done,
  output spq_pkg::status_t               status,
  output logic [ID_BITS-1:0]             removed_id,
  output logic [PRIORITY_BITS-1:0]       removed_priority,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for start
  localparam logic [2:0] S_INS   = 3'd1;  // walk from tail toward head, shifting up
  localparam logic [2:0] S_PLACE = 3'd2;  // drop new entry at cur
  localparam logic [2:0] S_HEAD  = 3'd3;  // head read data is back
  localparam logic [2:0] S_RM    = 3'd4;  // shift remaining entries down by one

  // entry store, one write and one registered read per cycle
  logic [PRIORITY_BITS-1:0] mem_prio [DEPTH];
  logic [ID_BITS-1:0]       mem_id   [DEPTH];
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]       rd_id;

  logic [2:0]               state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         cur, cur_next;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic [ID_BITS-1:0]       req_id;
  logic [PRIORITY_BITS-1:0] head_prio;
  logic [ID_BITS-1:0]       head_id;

  logic                     fin;
  spq_pkg::status_t         fin_status;
  logic [PRIORITY_BITS-1:0] fin_rprio;
  logic [ID_BITS-1:0]       fin_rid;
  logic                     head_load;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [PRIORITY_BITS-1:0] wr_prio;
  logic [ID_BITS-1:0]       wr_id;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;

  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         last_idx;
  logic                     rd_higher;

  assign busy      = (state != S_IDLE);
  assign occupancy = count;
  assign cnt_m1    = count - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];
  // the shared comparator: does the entry under the cursor stay ahead of the new one
  assign rd_higher = (rd_prio > req_prio);

  always_comb begin
    state_next = state;
    count_next = count;
    cur_next   = cur;
    fin        = 1'b0;
    fin_status = spq_pkg::ST_INSERTED;
    fin_rprio  = '0;
    fin_rid    = '0;
    head_load  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cur;
    wr_prio    = req_prio;
    wr_id      = req_id;
    rd_en      = 1'b0;
    rd_addr    = cur;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == spq_pkg::OP_REMOVE) begin
            if (count == '0) begin
              fin        = 1'b1;
              fin_status = spq_pkg::ST_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              cur_next   = '0;
              state_next = S_HEAD;
            end
          end else begin
            if (count == CNT_W'(DEPTH)) begin
              fin        = 1'b1;
              fin_status = spq_pkg::ST_FULL;
            end else if (count == '0) begin
              cur_next   = '0;
              state_next = S_PLACE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = last_idx;
              cur_next   = last_idx;
              state_next = S_INS;
            end
          end
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = cur + IDX_W'(1);
        if (rd_higher) begin
          // new entry lands right behind this one
          fin        = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = S_IDLE;
        end else begin
          wr_prio = rd_prio;
          wr_id   = rd_id;
          if (cur == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = cur - IDX_W'(1);
            cur_next = cur - IDX_W'(1);
          end
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = cur;
        fin        = 1'b1;
        count_next = count + CNT_W'(1);
        state_next = S_IDLE;
      end
      S_HEAD: begin
        head_load = 1'b1;
        if (count == CNT_W'(1)) begin
          fin        = 1'b1;
          fin_status = spq_pkg::ST_REMOVED;
          fin_rprio  = rd_prio;
          fin_rid    = rd_id;
          count_next = cnt_m1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(1);
          cur_next   = IDX_W'(1);
          state_next = S_RM;
        end
      end
      S_RM: begin
        wr_en   = 1'b1;
        wr_addr = cur - IDX_W'(1);
        wr_prio = rd_prio;
        wr_id   = rd_id;
        if (cur == last_idx) begin
          fin        = 1'b1;
          fin_status = spq_pkg::ST_REMOVED;
          fin_rprio  = head_prio;
          fin_rid    = head_id;
          count_next = cnt_m1;
          state_next = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = cur + IDX_W'(1);
          cur_next = cur + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (start && !busy) begin
      req_prio <= priority_req;
      req_id   <= client_id;
    end
    if (head_load) begin
      head_prio <= rd_prio;
      head_id   <= rd_id;
    end
    if (fin) begin
      status           <= fin_status;
      removed_priority <= fin_rprio;
      removed_id       <= fin_rid;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prio[wr_addr] <= wr_prio;
      mem_id[wr_addr]   <= wr_id;
    end
    if (rd_en) begin
      rd_prio <= mem_prio[rd_addr];
      rd_id   <= mem_id[rd_addr];
    end
  end

  // checks
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted transaction lost")
  `SPQ_ASSERT_NOW(a_count_moves_on_done, count != $past(count), done, "count changed without result")
  `SPQ_ASSERT_NOW(a_zero_unless_removed, done && status != spq_pkg::ST_REMOVED, removed_id == '0 && removed_priority == '0, "removed fields not zero")
  `SPQ_ASSERT_NOW(a_no_walk_when_full, state == S_INS, count < CNT_W'(DEPTH), "insert walk on full store")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_priority_queue_unit: a directed table, then random bursts.
// Each result is checked against its table value on typed rows, else against an in-bench model of the sorted store.
// Depends on spq_pkg and the RTL under rtl/.
module tb;

  localparam int DEPTH         = 16;
  localparam int PW            = 16;     // priority width
  localparam int IW            = 8;      // client id width
  localparam int OW            = 5;      // occupancy width, $clog2(DEPTH+1)
  localparam int RANDOM_ITEMS  = 625;
  localparam int TAIL_CYCLES   = 24;
  localparam int CYCLE_LIMIT   = 200000;

  // one result as seen on the result ports
  typedef struct packed {
    spq_pkg::status_t status;
    logic [IW-1:0]    rid;
    logic [PW-1:0]    rprio;
    logic [OW-1:0]    occ;
  } result_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    logic            op;
    logic [PW-1:0]   prio;
    logic [IW-1:0]   cid;
    bit              typed;
    result_t         want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             operation = spq_pkg::OP_INSERT;
  logic [PW-1:0]    priority_req = '0;
  logic [IW-1:0]    client_id = '0;
  logic             busy;
  logic             done;
  spq_pkg::status_t status;
  logic [IW-1:0]    removed_id;
  logic [PW-1:0]    removed_priority;
  logic [OW-1:0]    occupancy;

  sorted_priority_queue_unit #(
    .DEPTH(DEPTH),
    .PRIORITY_BITS(PW),
    .ID_BITS(IW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .priority_req(priority_req),
    .client_id(client_id),
    .done(done),
    .status(status),
    .removed_id(removed_id),
    .removed_priority(removed_priority),
    .occupancy(occupancy)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: entries kept highest priority first, head at index 0.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] held_prio [DEPTH];
  logic [IW-1:0] held_id   [DEPTH];
  int            held_count = 0;
  int            peak_count = 0;

  // Applies one transaction to the model and returns the result it must give.
  function automatic result_t predict_queue_op(logic op, logic [PW-1:0] prio,
                                               logic [IW-1:0] cid);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // land in front of the first entry that is not strictly higher,
        // so the newest of equal priorities is served first
        pos = 0;
        while (pos < held_count && held_prio[pos] > prio) pos++;
        for (i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_id[i]   = held_id[i-1];
        end
        held_prio[pos] = prio;
        held_id[pos]   = cid;
        held_count++;
        r.status = spq_pkg::ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.status = spq_pkg::ST_REMOVED;
      r.rid    = held_id[0];
      r.rprio  = held_prio[0];
      for (i = 1; i < held_count; i++) begin
        held_prio[i-1] = held_prio[i];
        held_id[i-1]   = held_id[i];
      end
      held_count--;
    end
    if (held_count > peak_count) peak_count = held_count;
    r.occ = OW'(held_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results, oldest first, and run statistics.
  // ---------------------------------------------------------------------------
  result_t pending_results[$];
  int      errors = 0;
  int      issued = 0;
  int      cnt_inserted = 0;
  int      cnt_removed = 0;
  int      cnt_empty = 0;
  int      cnt_full = 0;
  int      cycles = 0;

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Results are sampled at the edge that ends the done cycle; outputs move by
  // nonblocking updates, so the values read here are the ones being accepted.
  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (!rst && done) begin
      got = {status, removed_id, removed_priority, occupancy};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d id %0d prio %0d occ %0d",
                 $time, got.status, got.rid, got.rprio, got.occ);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("removed_id", 32'(want.rid), 32'(got.rid));
        check_field("removed_priority", 32'(want.rprio), 32'(got.rprio));
        check_field("occupancy", 32'(want.occ), 32'(got.occ));
        case (want.status)
          spq_pkg::ST_INSERTED: cnt_inserted++;
          spq_pkg::ST_REMOVED:  cnt_removed++;
          spq_pkg::ST_EMPTY:    cnt_empty++;
          default:              cnt_full++;
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no finish within %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the transaction
  // is accepted. start is left high so back-to-back transactions need no drop.
  // ---------------------------------------------------------------------------
  task automatic issue(logic op, logic [PW-1:0] prio, logic [IW-1:0] cid,
                       bit typed, result_t want);
    result_t predicted;
    start        <= 1'b1;
    operation    <= op;
    priority_req <= prio;
    client_id    <= cid;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_queue_op(op, prio, cid);
    pending_results.push_back(typed ? want : predicted);
    issued++;
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t make_row(logic op, logic [PW-1:0] prio, logic [IW-1:0] cid,
                                         bit typed, spq_pkg::status_t st,
                                         logic [OW-1:0] occ);
    stim_row_t r;
    r.op         = op;
    r.prio       = prio;
    r.cid        = cid;
    r.typed      = typed;
    r.want       = '0;
    r.want.status = st;
    r.want.occ   = occ;
    return r;
  endfunction

  initial begin
    stim_row_t     rows[$];
    stim_row_t     row;
    int            k;
    int            left;
    int            burst;
    int            gap;
    int            insert_pct;
    logic          op;
    logic [PW-1:0] prio;
    logic [IW-1:0] cid;

    // Directed table. Typed rows are the ones obvious by inspection.
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 1,
                            spq_pkg::ST_EMPTY, 5'd0));    // empty remove
    rows.push_back(make_row(spq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 1,
                            spq_pkg::ST_INSERTED, 5'd1)); // top priority
    rows.push_back(make_row(spq_pkg::OP_INSERT, 16'h0000, 8'h00, 1,
                            spq_pkg::ST_INSERTED, 5'd2)); // bottom priority
    rows.push_back(make_row(spq_pkg::OP_INSERT, 16'hFFFF, 8'h5A, 0,
                            spq_pkg::ST_INSERTED, 5'd0)); // tie, goes first
    rows.push_back(make_row(spq_pkg::OP_INSERT, 16'h8000, 8'hA5, 0,
                            spq_pkg::ST_INSERTED, 5'd0));
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'h0000, 8'h00, 0,
                            spq_pkg::ST_REMOVED, 5'd0));
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'h5555, 8'hAA, 0,
                            spq_pkg::ST_REMOVED, 5'd0));
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'hAAAA, 8'h55, 0,
                            spq_pkg::ST_REMOVED, 5'd0));
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 0,
                            spq_pkg::ST_REMOVED, 5'd0));
    rows.push_back(make_row(spq_pkg::OP_REMOVE, 16'h0000, 8'h00, 1,
                            spq_pkg::ST_EMPTY, 5'd0));    // drained again
    // fill to the brim with heavy priority ties
    for (k = 0; k < DEPTH; k++) begin
      prio = (k == DEPTH - 1) ? 16'hFFFF : PW'(k % 3) * 16'h7FFF;
      rows.push_back(make_row(spq_pkg::OP_INSERT, prio, IW'(k * 37), 0,
                              spq_pkg::ST_INSERTED, 5'd0));
    end
    rows.push_back(make_row(spq_pkg::OP_INSERT, 16'h1234, 8'h99, 1,
                            spq_pkg::ST_FULL, 5'd16));    // refused, full

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      row = rows[k];
      issue(row.op, row.prio, row.cid, row.typed, row.want);
      if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 5));
    end
    // let the whole directed part settle before random traffic
    wait_drained();
    @(posedge clk);

    // Random bursts. Each burst leans toward filling, draining or neither, so
    // the store swings between empty and full many times.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        case ($urandom_range(0, 3))
          0:       prio = PW'($urandom_range(0, 3));             // dense ties at the bottom
          1:       prio = PW'($urandom);
          2:       prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: prio = PW'($urandom_range(16'h7FFE, 16'h8001)); // around the MSB flip
        endcase
        cid = IW'($urandom);
        issue(op, prio, cid, 0, '0);
        left--;
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) idle_for(gap);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d inserts, %0d removes, %0d removes on empty,",
             issued, cnt_inserted, cnt_removed, cnt_empty);
    $display("%0d inserts refused while full, peak occupancy %0d, %0d mismatches.",
             cnt_full, peak_count, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
